// File: sv/cursor_array_list_unit_macros.svh
// assertion macros for the cursor array list checker
`ifndef CURSOR_ARRAY_LIST_UNIT_MACROS_SVH
`define CURSOR_ARRAY_LIST_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CAL_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error("cal checker: same-cycle rule violated");

// next-cycle implication, disabled while reset is asserted
`define CAL_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error("cal checker: next-cycle rule violated");

`endif

// File: sv/cal_pkg.sv
`default_nettype none

package cal_pkg;

	// operation codes
	localparam logic [3:0] OP_INS_BEFORE = 4'd0;
	localparam logic [3:0] OP_INS_AFTER  = 4'd1;
	localparam logic [3:0] OP_DELETE     = 4'd2;
	localparam logic [3:0] OP_PREV       = 4'd3;
	localparam logic [3:0] OP_NEXT       = 4'd4;
	localparam logic [3:0] OP_FIRST      = 4'd5;
	localparam logic [3:0] OP_LAST       = 4'd6;
	localparam logic [3:0] OP_READ_CUR   = 4'd7;
	localparam logic [3:0] OP_WRITE_CUR  = 4'd8;
	localparam logic [3:0] OP_READ_AT    = 4'd9;
	localparam logic [3:0] OP_WRITE_AT   = 4'd10;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_BAD_INDEX = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_REFUSED   = 3'd4;

	// request payload
	typedef struct packed {
		logic [3:0]  operation;
		logic [31:0] value;
		logic [9:0]  position;
	} req_t;

	// result payload
	typedef struct packed {
		logic [31:0] read_data;
		logic [2:0]  status;
		logic [10:0] element_count;
		logic [9:0]  cursor_pos;
	} rsp_t;

endpackage

`default_nettype wire

// File: sv/cal_chan_if.sv
`default_nettype none

// valid/ready channel carrying one payload word per request
interface cal_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/cursor_array_list_unit.sv
`default_nettype none

// channel  dir  payload                                         request taken when
// req      in   operation[3:0] value[31:0] position[9:0]        req.valid & req.ready
// rsp      out  read_data[31:0] status[2:0] element_count[10:0] rsp.valid & rsp.ready
//                cursor_pos[9:0]
//
// one request at a time; ready is high whenever the sequencer is idle, even while
// a result waits in the output register
// a read passes through a read state; an insert that moves n entries runs a shift loop
// and then writes the new word into the opened slot (one that moves none writes it
// directly), and a delete that moves n entries (at most DEPTH-1) runs its own shift loop;
// the single write port of the element store moves one entry per cycle
// reset clears count, cursor and control; stored words are undefined until written
// a stalled rsp holds the finished result while the next request is decoded

module cursor_array_list_unit import cal_pkg::*; #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	cal_chan_if.sink   req,
	cal_chan_if.source rsp
);

	localparam int AW = $clog2(DEPTH);

	logic                  done_valid;
	logic                  done_ready;
	rsp_t                  done_rsp;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic                  mem_wr_en;
	logic [AW-1:0]         mem_wr_addr;
	logic [DATA_WIDTH-1:0] mem_wr_data;
	logic                  mem_rd_en;
	logic [AW-1:0]         mem_rd_addr;
	logic [DATA_WIDTH-1:0] mem_rd_data;

	cal_seq #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_ready    (req.ready),
		.in_req      (req.payload),
		.out_valid   (done_valid),
		.out_ready   (done_ready),
		.out_rsp     (done_rsp),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	cal_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// output register takes a new result when empty or being drained
	assign done_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_ready) begin
			rsp_valid_q <= done_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (done_ready && done_valid) begin
			rsp_q <= done_rsp;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

`default_nettype wire

// File: sv/cal_mem.sv
`default_nettype none

// element store: one write port, one read port with registered data
module cal_mem #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_WIDTH-1:0]    wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_WIDTH-1:0]    rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/cal_seq.sv
`default_nettype none

// list sequencer: decodes requests, keeps count and cursor, runs the shift loops
module cal_seq import cal_pkg::*; #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  req_t                     in_req,
	output logic                     out_valid,
	input  logic                     out_ready,
	output rsp_t                     out_rsp,
	output logic                     mem_wr_en,
	output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
	output logic [DATA_WIDTH-1:0]    mem_wr_data,
	output logic                     mem_rd_en,
	output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
	input  logic [DATA_WIDTH-1:0]    mem_rd_data
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 10) ? CW : 10;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UP   = 3'd1;
	localparam logic [2:0] S_SLOT = 3'd2;
	localparam logic [2:0] S_DOWN = 3'd3;
	localparam logic [2:0] S_READ = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]            state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [AW-1:0]         cursor_q, cursor_d;
	logic [AW-1:0]         k_q, k_d;
	logic [AW-1:0]         slot_q, slot_d;
	logic [AW-1:0]         last_q, last_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	logic [DATA_WIDTH-1:0] rd_q, rd_d;
	logic [2:0]            st_q, st_d;

	logic                  empty;
	logic [AW-1:0]         slot;
	logic [CW-1:0]         cursor_inc;
	logic                  pos_bad;

	// request-side helpers
	always_comb begin
		empty      = (count_q == '0);
		slot       = (in_req.operation == OP_INS_BEFORE) ? cursor_q : cursor_q + AW'(1);
		cursor_inc = CW'(cursor_q) + CW'(1);
		pos_bad    = (CMPW'(in_req.position) >= CMPW'(count_q));
	end

	// next state and memory control
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cursor_d    = cursor_q;
		k_d         = k_q;
		slot_d      = slot_q;
		last_d      = last_q;
		val_d       = val_q;
		rd_d        = rd_q;
		st_d        = st_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = '0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					st_d    = ST_OK;
					rd_d    = '0;
					val_d   = DATA_WIDTH'(in_req.value);
					state_d = S_DONE;
					case (in_req.operation)
						OP_INS_BEFORE, OP_INS_AFTER: begin
							if (count_q == CW'(DEPTH)) begin
								st_d = ST_FULL;
							end else if (empty) begin
								mem_wr_en   = 1'b1;
								mem_wr_addr = '0;
								mem_wr_data = DATA_WIDTH'(in_req.value);
								count_d     = CW'(1);
								cursor_d    = '0;
							end else begin
								count_d = count_q + CW'(1);
								if (in_req.operation == OP_INS_BEFORE) begin
									cursor_d = cursor_q + AW'(1);
								end
								if (CW'(slot) == count_q) begin
									// appending behind the last entry, nothing to move
									mem_wr_en   = 1'b1;
									mem_wr_addr = slot;
									mem_wr_data = DATA_WIDTH'(in_req.value);
								end else begin
									mem_rd_en   = 1'b1;
									mem_rd_addr = AW'(count_q - CW'(1));
									k_d         = AW'(count_q);
									slot_d      = slot;
									state_d     = S_UP;
								end
							end
						end
						OP_DELETE: begin
							if (empty) begin
								st_d = ST_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
								if (count_q == CW'(1)) begin
									cursor_d = '0;
								end else if (cursor_inc >= count_q) begin
									cursor_d = AW'(count_q - CW'(2));
								end
								if (cursor_inc < count_q) begin
									mem_rd_en   = 1'b1;
									mem_rd_addr = cursor_q + AW'(1);
									k_d         = cursor_q;
									last_d      = AW'(count_q - CW'(1));
									state_d     = S_DOWN;
								end
							end
						end
						OP_PREV: begin
							if (empty || cursor_q == '0) begin
								st_d = ST_REFUSED;
							end else begin
								cursor_d = cursor_q - AW'(1);
							end
						end
						OP_NEXT: begin
							if (empty || cursor_inc >= count_q) begin
								st_d = ST_REFUSED;
							end else begin
								cursor_d = cursor_q + AW'(1);
							end
						end
						OP_FIRST: begin
							if (empty) begin
								st_d = ST_EMPTY;
							end else begin
								cursor_d = '0;
							end
						end
						OP_LAST: begin
							if (empty) begin
								st_d = ST_EMPTY;
							end else begin
								cursor_d = AW'(count_q - CW'(1));
							end
						end
						OP_READ_CUR: begin
							if (empty) begin
								st_d = ST_EMPTY;
							end else begin
								mem_rd_en   = 1'b1;
								mem_rd_addr = cursor_q;
								state_d     = S_READ;
							end
						end
						OP_WRITE_CUR: begin
							if (empty) begin
								st_d = ST_EMPTY;
							end else begin
								mem_wr_en   = 1'b1;
								mem_wr_addr = cursor_q;
								mem_wr_data = DATA_WIDTH'(in_req.value);
							end
						end
						OP_READ_AT: begin
							if (pos_bad) begin
								st_d = ST_BAD_INDEX;
							end else begin
								mem_rd_en   = 1'b1;
								mem_rd_addr = AW'(in_req.position);
								state_d     = S_READ;
							end
						end
						OP_WRITE_AT: begin
							if (pos_bad) begin
								st_d = ST_BAD_INDEX;
							end else begin
								mem_wr_en   = 1'b1;
								mem_wr_addr = AW'(in_req.position);
								mem_wr_data = DATA_WIDTH'(in_req.value);
							end
						end
						default: begin
							st_d = ST_OK;
						end
					endcase
				end
			end
			// move entry k-1 up to k, fetch the next one while writing
			S_UP: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = k_q;
				mem_wr_data = mem_rd_data;
				if (k_q - AW'(1) != slot_q) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = k_q - AW'(2);
					k_d         = k_q - AW'(1);
				end else begin
					state_d = S_SLOT;
				end
			end
			// place the new word in the opened slot
			S_SLOT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = slot_q;
				mem_wr_data = val_q;
				state_d     = S_DONE;
			end
			// move entry k+1 down to k
			S_DOWN: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = k_q;
				mem_wr_data = mem_rd_data;
				if (k_q + AW'(1) < last_q) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = k_q + AW'(2);
					k_d         = k_q + AW'(1);
				end else begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				rd_d    = mem_rd_data;
				state_d = S_DONE;
			end
			// hand the result to the output register
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result word
	always_comb begin
		out_rsp.read_data     = 32'(rd_q);
		out_rsp.status        = st_q;
		out_rsp.element_count = 11'(count_q);
		out_rsp.cursor_pos    = (count_q == '0) ? 10'd0 : 10'(cursor_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		k_q    <= k_d;
		slot_q <= slot_d;
		last_q <= last_d;
		val_q  <= val_d;
		rd_q   <= rd_d;
		st_q   <= st_d;
	end

endmodule

`default_nettype wire

// File: sv/cal_checker.sv
`default_nettype none

`include "cursor_array_list_unit_macros.svh"

// port-level checks on the list unit
module cal_checker import cal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_payload
);

	// one request in flight: the unit is busy right after taking one
	`CAL_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)

	// a stalled result stays put
	`CAL_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

	// refused operations return no data
	`CAL_ASSERT_IMP(a_no_data_on_error, clk, arst_n, rsp_valid && rsp_payload.status != ST_OK, rsp_payload.read_data == 32'd0)

	// empty status only comes from an empty list
	`CAL_ASSERT_IMP(a_empty_count, clk, arst_n, rsp_valid && rsp_payload.status == ST_EMPTY, rsp_payload.element_count == 11'd0)

endmodule

bind cursor_array_list_unit cal_checker u_cal_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

`default_nettype wire
